>>> rtl/core/ogpb_pkg.sv
// shared types and constants for the oled glyph page blitter
// no dependencies
package ogpb_pkg;

    localparam int unsigned NUM_LANES        = 8;
    localparam int unsigned COLUMN_OFFSET_DEF = 2;
    localparam int unsigned MAX_X            = 119;
    localparam int unsigned MAX_Y            = 55;

    localparam logic [6:0] DEV_ADDR_RESET = 7'd60;

    localparam logic [7:0] CTRL_CMD   = 8'h80;
    localparam logic [7:0] CTRL_DATA  = 8'h40;
    localparam logic [7:0] CMD_PAGE   = 8'hB0;
    localparam logic [7:0] CMD_COL_LO = 8'h00;
    localparam logic [7:0] CMD_COL_HI = 8'h10;
    localparam logic [3:0] NIBBLE     = 4'hF;

    // byte positions within one page sequence
    localparam logic [4:0] POS_ADDR_PAGE = 5'd0;
    localparam logic [4:0] POS_CTRL_PAGE = 5'd1;
    localparam logic [4:0] POS_CMD_PAGE  = 5'd2;
    localparam logic [4:0] POS_ADDR_LO   = 5'd3;
    localparam logic [4:0] POS_CTRL_LO   = 5'd4;
    localparam logic [4:0] POS_CMD_LO    = 5'd5;
    localparam logic [4:0] POS_ADDR_HI   = 5'd6;
    localparam logic [4:0] POS_CTRL_HI   = 5'd7;
    localparam logic [4:0] POS_CMD_HI    = 5'd8;
    localparam logic [4:0] POS_ADDR_DATA = 5'd9;
    localparam logic [4:0] POS_CTRL_DATA = 5'd10;
    localparam logic [4:0] POS_DATA_0    = 5'd11;
    localparam logic [4:0] POS_DATA_LAST = 5'd18;

    typedef struct packed {
        logic [NUM_LANES-1:0][7:0] lo;
        logic [NUM_LANES-1:0][7:0] hi;
        logic [2:0]                page;
        logic [6:0]                col;
        logic                      two_pages;
    } t_job;

endpackage

>>> rtl/core/ogpb_lane.sv
// one column lane: optional transpose, shift by row offset, split into two pages
// depends on ogpb_pkg
module ogpb_lane #(
    parameter int unsigned LANE = 0
) (
    input  logic [ogpb_pkg::NUM_LANES*8-1:0] i_glyph,
    input  logic                             i_rows,
    input  logic [2:0]                       i_shift,
    output logic [7:0]                       o_lo,
    output logic [7:0]                       o_hi
);
    import ogpb_pkg::*;

    logic [7:0]  col_byte;
    logic [7:0]  tr_byte;
    logic [15:0] shifted;

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            tr_byte[j] = i_glyph[8*j + LANE];
        end
    end

    assign col_byte = i_rows ? tr_byte : i_glyph[8*LANE +: 8];
    assign shifted  = {8'd0, col_byte} << i_shift;
    assign o_lo     = shifted[7:0];
    assign o_hi     = shifted[15:8];

endmodule

>>> rtl/core/ogpb_serializer.sv
// merges lane results into the bus byte stream, one byte per transfer
// depends on ogpb_pkg
module ogpb_serializer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [6:0]       i_dev_addr,
    input  logic             i_job_valid,
    input  ogpb_pkg::t_job   i_job,
    output logic             o_job_ready,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_bus_byte,
    output logic             o_frame_start,
    output logic             o_frame_end,
    output logic             o_last
);
    import ogpb_pkg::*;

    logic       r_busy, n_busy;
    logic [4:0] r_pos, n_pos;
    logic       r_second, n_second;
    t_job       r_cur;

    logic       out_xfer;
    logic       seq_end;
    logic [2:0] page_now;
    logic [7:0] addr_byte;
    logic [2:0] data_idx;
    logic [7:0] data_byte;

    assign out_xfer    = r_busy && i_ready;
    assign seq_end     = (r_pos == POS_DATA_LAST) && (r_second || !r_cur.two_pages);
    assign o_job_ready = !r_busy || (out_xfer && seq_end);
    assign o_valid     = r_busy;
    assign o_last      = seq_end;

    assign page_now  = r_cur.page + {2'd0, r_second};
    assign addr_byte = {i_dev_addr, 1'b0};
    assign data_idx  = 3'(r_pos - POS_DATA_0);
    assign data_byte = r_second ? r_cur.hi[data_idx] : r_cur.lo[data_idx];

    always_comb begin
        o_bus_byte    = data_byte;
        o_frame_start = 1'b0;
        o_frame_end   = 1'b0;
        case (r_pos)
            POS_ADDR_PAGE, POS_ADDR_LO, POS_ADDR_HI, POS_ADDR_DATA: begin
                o_bus_byte    = addr_byte;
                o_frame_start = 1'b1;
            end
            POS_CTRL_PAGE, POS_CTRL_LO, POS_CTRL_HI: begin
                o_bus_byte = CTRL_CMD;
            end
            POS_CTRL_DATA: begin
                o_bus_byte = CTRL_DATA;
            end
            POS_CMD_PAGE: begin
                o_bus_byte  = CMD_PAGE | {5'd0, page_now};
                o_frame_end = 1'b1;
            end
            POS_CMD_LO: begin
                o_bus_byte  = CMD_COL_LO | {4'd0, r_cur.col[3:0] & NIBBLE};
                o_frame_end = 1'b1;
            end
            POS_CMD_HI: begin
                o_bus_byte  = CMD_COL_HI | {4'd0, {1'b0, r_cur.col[6:4]} & NIBBLE};
                o_frame_end = 1'b1;
            end
            POS_DATA_LAST: begin
                o_bus_byte  = data_byte;
                o_frame_end = 1'b1;
            end
            default: begin
                o_bus_byte = data_byte;
            end
        endcase
    end

    always_comb begin
        n_busy   = r_busy;
        n_pos    = r_pos;
        n_second = r_second;
        if (o_job_ready) begin
            n_busy   = i_job_valid;
            n_pos    = POS_ADDR_PAGE;
            n_second = 1'b0;
        end else if (out_xfer) begin
            if (r_pos == POS_DATA_LAST) begin
                n_pos    = POS_ADDR_PAGE;
                n_second = 1'b1;
            end else begin
                n_pos = r_pos + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_pos    <= POS_ADDR_PAGE;
            r_second <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_pos    <= n_pos;
            r_second <= n_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_ready && i_job_valid) begin
            r_cur <= i_job;
        end
    end

endmodule

>>> rtl/core/oled_glyph_page_blitter_top.sv
// top level of the oled glyph page blitter: clamp, column lanes, job register, serializer
// depends on ogpb_pkg, ogpb_lane, ogpb_serializer
//
// channel  | signals                                        | dir
// glyph in | i_valid, o_ready, i_x_pos, i_y_pos,            | in
//          | i_glyph_bits, i_rows_given                     |
// bus out  | o_valid, i_ready, o_bus_byte, o_frame_start,   | out
//          | o_frame_end, o_last                            |
// config   | i_cfg_we, i_cfg_data                           | in
//
// a glyph yields 19 bytes (page aligned row) or 38 bytes, one per output transfer,
// all of them sent by the byte serializer
// lanes and clamp finish in the accept cycle; the job register holds one glyph
// while the previous one streams, so a waiting glyph follows its last byte directly
// output stall freezes the serializer; reset empties both stages and loads address 60
module oled_glyph_page_blitter_top #(
    parameter int unsigned COLUMN_OFFSET = ogpb_pkg::COLUMN_OFFSET_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [6:0]         i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_x_pos,
    input  logic signed [15:0] i_y_pos,
    input  logic [63:0]        i_glyph_bits,
    input  logic               i_rows_given,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_bus_byte,
    output logic               o_frame_start,
    output logic               o_frame_end,
    output logic               o_last
);
    import ogpb_pkg::*;

    logic [6:0] r_dev_addr;
    logic       r_job_valid, n_job_valid;
    t_job       r_job;
    t_job       n_job;
    logic       job_ready;
    logic       in_xfer;
    logic [6:0] x_cl;
    logic [5:0] y_cl;

    assign o_ready = !r_job_valid || job_ready;
    assign in_xfer = i_valid && o_ready;

    always_comb begin
        if (i_x_pos < 0) begin
            x_cl = 7'd0;
        end else if (i_x_pos > 16'(MAX_X)) begin
            x_cl = 7'(MAX_X);
        end else begin
            x_cl = i_x_pos[6:0];
        end
        if (i_y_pos < 0) begin
            y_cl = 6'd0;
        end else if (i_y_pos > 16'(MAX_Y)) begin
            y_cl = 6'(MAX_Y);
        end else begin
            y_cl = i_y_pos[5:0];
        end
    end

    assign n_job.page      = y_cl[5:3];
    assign n_job.col       = 7'(x_cl + 7'(COLUMN_OFFSET));
    assign n_job.two_pages = (y_cl[2:0] != 3'd0);

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        ogpb_lane #(
            .LANE(g)
        ) u_lane (
            .i_glyph (i_glyph_bits),
            .i_rows  (i_rows_given),
            .i_shift (y_cl[2:0]),
            .o_lo    (n_job.lo[g]),
            .o_hi    (n_job.hi[g])
        );
    end

    always_comb begin
        n_job_valid = r_job_valid;
        if (job_ready) begin
            n_job_valid = 1'b0;
        end
        if (in_xfer) begin
            n_job_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr  <= DEV_ADDR_RESET;
            r_job_valid <= 1'b0;
        end else begin
            r_job_valid <= n_job_valid;
            if (i_cfg_we) begin
                r_dev_addr <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_job <= n_job;
        end
    end

    ogpb_serializer u_serializer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_dev_addr    (r_dev_addr),
        .i_job_valid   (r_job_valid),
        .i_job         (r_job),
        .o_job_ready   (job_ready),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_bus_byte    (o_bus_byte),
        .o_frame_start (o_frame_start),
        .o_frame_end   (o_frame_end),
        .o_last        (o_last)
    );

endmodule
